// ----- hw/rtl/aes_key_expansion_assert.svh -----
// ----------------------------------------------------------------------------
// AES key expansion assertion macros
// Shared forms for the concurrent checks on the key expansion block.
// ----------------------------------------------------------------------------
`ifndef AES_KEY_EXPANSION_ASSERT_SVH
`define AES_KEY_EXPANSION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define AESK_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aes key expansion: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define AESK_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aes key expansion: next-cycle check failed");

`endif

// ----- hw/rtl/aesk_pkg.sv -----
// ----------------------------------------------------------------------------
// AES key expansion package
// Shared widths, key size codes, S-box table and ring control struct.
// ----------------------------------------------------------------------------
package aesk_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_CELLS = 8;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned LOADED_W  = 4;

  // Key size codes
  localparam logic [MODE_W-1:0] MODE_128 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_192 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_256 = 2'd2;

  // Position of the newest key word (Nk - 1)
  localparam logic [POS_W-1:0] LAST_KEY_128 = 3'd3;
  localparam logic [POS_W-1:0] LAST_KEY_192 = 3'd5;
  localparam logic [POS_W-1:0] LAST_KEY_256 = 3'd7;

  // Number of the last schedule word (4*(Nr+1) - 1)
  localparam logic [IDX_W-1:0] LAST_WORD_128 = 6'd43;
  localparam logic [IDX_W-1:0] LAST_WORD_192 = 6'd51;
  localparam logic [IDX_W-1:0] LAST_WORD_256 = 6'd59;

  // Phase of the extra SubWord for 256-bit keys
  localparam logic [POS_W-1:0] SUB_PHASE = 3'd4;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  // Control from the sequencer to the word ring and the datapath
  typedef struct packed {
    logic             load_en;   // write key word into cell load_pos
    logic [POS_W-1:0] load_pos;
    logic             shift_en;  // rotate ring cells 0..last_pos by one
    logic [POS_W-1:0] last_pos;  // ring end, Nk - 1
    logic             rot_en;    // RotWord + SubWord + Rcon step
    logic             sub_en;    // SubWord only (256-bit keys)
    logic             echo;      // output takes the key word
    logic             out_load;  // output data register loads
  } ring_ctrl_t;

  // S-box on all four bytes of a word
  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

// ----- hw/rtl/aesk_cell.sv -----
// ----------------------------------------------------------------------------
// AES key expansion ring cell
// Holds one window word; loads a key word or takes its neighbor's word (ring end: new word).
// ----------------------------------------------------------------------------
module aesk_cell (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic                       shift_i,
  input  logic                       last_i,
  input  logic [aesk_pkg::WORD_W-1:0] key_word_i,
  input  logic [aesk_pkg::WORD_W-1:0] new_word_i,
  input  logic [aesk_pkg::WORD_W-1:0] next_word_i,
  output logic [aesk_pkg::WORD_W-1:0] word_o
);
  import aesk_pkg::*;

  logic [WORD_W-1:0] word_q;

  // Ring end takes the fresh schedule word, others take their neighbor
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= key_word_i;
    end else if (shift_i) begin
      word_q <= last_i ? new_word_i : next_word_i;
    end
  end

  assign word_o = word_q;

endmodule

// ----- hw/rtl/aesk_ctrl.sv -----
// ----------------------------------------------------------------------------
// AES key expansion sequencer
// Handshakes, key word count, schedule counters, round constant and mode.
// ----------------------------------------------------------------------------
module aesk_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aesk_pkg::MODE_W-1:0]  key_size_mode_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [aesk_pkg::IDX_W-1:0]   word_number_o,
  output logic                         final_word_o,
  output logic [7:0]                   rcon_o,
  output aesk_pkg::ring_ctrl_t         ring_o
);
  import aesk_pkg::*;

  localparam logic ST_LOAD   = 1'b0;
  localparam logic ST_EXPAND = 1'b1;

  logic                state_q, state_d;
  logic [MODE_W-1:0]   mode_q;
  logic [LOADED_W-1:0] loaded_q, loaded_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [POS_W-1:0]    phase_q, phase_d;
  logic [7:0]          rcon_q, rcon_d;
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    num_q, num_d;
  logic                final_q, final_d;

  logic [POS_W-1:0] last_key;
  logic [IDX_W-1:0] last_word;
  logic [POS_W-1:0] pos;
  logic             out_free, accept, step, is_last_word;

  // Key size decode; the unused code acts as 256-bit
  always_comb begin
    case (mode_q)
      MODE_128: begin
        last_key  = LAST_KEY_128;
        last_word = LAST_WORD_128;
      end
      MODE_192: begin
        last_key  = LAST_KEY_192;
        last_word = LAST_WORD_192;
      end
      default: begin
        last_key  = LAST_KEY_256;
        last_word = LAST_WORD_256;
      end
    endcase
  end

  assign out_free     = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == ST_LOAD) && out_free;
  assign accept       = in_valid_i && in_ready_o;
  assign step         = (state_q == ST_EXPAND) && out_free;
  assign is_last_word = (idx_q == last_word);
  assign cfg_ready_o  = 1'b1;

  // Key word slot, clamped to the ring end if the mode shrank mid-load
  assign pos = (loaded_q > {1'b0, last_key}) ? last_key : loaded_q[POS_W-1:0];

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    rcon_d      = rcon_q;
    num_d       = num_q;
    final_d     = final_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      num_d       = {{(IDX_W-POS_W){1'b0}}, pos};
      final_d     = 1'b0;
      if (pos == last_key) begin
        state_d  = ST_EXPAND;
        loaded_d = '0;
        idx_d    = {{(IDX_W-POS_W){1'b0}}, last_key} + IDX_W'(1);
        phase_d  = '0;
      end else begin
        loaded_d = LOADED_W'(pos) + LOADED_W'(1);
      end
    end
    if (step) begin
      out_valid_d = 1'b1;
      num_d       = idx_q;
      final_d     = is_last_word;
      idx_d       = idx_q + IDX_W'(1);
      phase_d     = (phase_q == last_key) ? '0 : phase_q + POS_W'(1);
      if (phase_q == '0) begin
        rcon_d = xtime(rcon_q);
      end
      if (is_last_word) begin
        state_d = ST_LOAD;
        rcon_d  = RCON_INIT;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      mode_q      <= MODE_128;
      loaded_q    <= '0;
      idx_q       <= '0;
      phase_q     <= '0;
      rcon_q      <= RCON_INIT;
      out_valid_q <= 1'b0;
      num_q       <= '0;
      final_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      rcon_q      <= rcon_d;
      out_valid_q <= out_valid_d;
      num_q       <= num_d;
      final_q     <= final_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= key_size_mode_i;
      end
    end
  end

  // Ring and datapath control
  always_comb begin
    ring_o.load_en  = accept;
    ring_o.load_pos = pos;
    ring_o.shift_en = step;
    ring_o.last_pos = last_key;
    ring_o.rot_en   = (phase_q == '0);
    ring_o.sub_en   = (last_key == LAST_KEY_256) && (phase_q == SUB_PHASE);
    ring_o.echo     = accept;
    ring_o.out_load = accept || step;
  end

  assign rcon_o        = rcon_q;
  assign out_valid_o   = out_valid_q;
  assign word_number_o = num_q;
  assign final_word_o  = final_q;

endmodule

// ----- hw/rtl/aes_key_expansion.sv -----
// ----------------------------------------------------------------------------
// AES key expansion
// Expands a 128, 192 or 256-bit cipher key into the AES key schedule.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_size_mode_i (0: 128, 1: 192, 2 or 3: 256 bits) on the cfg
//   channel while the block is idle, then send the cipher key one 32-bit
//   word per item on the input channel, first byte in bits 31..24.
//   Each key word comes back in the cycle after it is taken, as schedule
//   word 0..Nk-1. The last key word starts the expansion: the remaining
//   40, 46 or 52 words follow at one word per cycle while the output is
//   not stalled, final_word_o marks word 43, 51 or 59. A key therefore
//   takes Nk input items and 44, 52 or 60 output items.
//   The rate is set by the ring of eight word cells: each unstalled cycle
//   one new word is computed from the ring end and the oldest cell, and the
//   ring rotates by one. No new key word is taken during the expansion.
//   A single output register holds each word; when the receiver stalls the
//   expansion pauses with it and nothing is lost.
//   Reset clears the key word count, the round constant and the mode (128
//   bits); the window cells are not reset and are only read once written.
// ----------------------------------------------------------------------------
module aes_key_expansion (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aesk_pkg::MODE_W-1:0]  key_size_mode_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [aesk_pkg::WORD_W-1:0]  key_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [aesk_pkg::WORD_W-1:0]  schedule_word_o,
  output logic [aesk_pkg::IDX_W-1:0]   word_number_o,
  output logic                         final_word_o
);
  import aesk_pkg::*;

  ring_ctrl_t        ring;
  logic [7:0]        rcon;
  logic [WORD_W-1:0] cell_word [NUM_CELLS];
  logic [WORD_W-1:0] prev_word, rot_word, subbed, temp, new_word;
  logic [WORD_W-1:0] sched_q, sched_d;

  aesk_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .key_size_mode_i (key_size_mode_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .word_number_o   (word_number_o),
    .final_word_o    (final_word_o),
    .rcon_o          (rcon),
    .ring_o          (ring)
  );

  // Ring of window cells; cell 0 is the oldest word, cell Nk-1 the newest
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    logic [WORD_W-1:0] next_word;
    if (j == NUM_CELLS - 1) begin : g_end
      assign next_word = new_word;
    end else begin : g_mid
      assign next_word = cell_word[j+1];
    end
    aesk_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (ring.load_en && (ring.load_pos == POS_W'(j))),
      .shift_i     (ring.shift_en && (POS_W'(j) <= ring.last_pos)),
      .last_i      (ring.last_pos == POS_W'(j)),
      .key_word_i  (key_word_i),
      .new_word_i  (new_word),
      .next_word_i (next_word),
      .word_o      (cell_word[j])
    );
  end

  // Newest word sits at the ring end
  always_comb begin
    case (ring.last_pos)
      LAST_KEY_128: prev_word = cell_word[3];
      LAST_KEY_192: prev_word = cell_word[5];
      default:      prev_word = cell_word[7];
    endcase
  end

  // RotWord / SubWord / Rcon, then XOR with the word Nk places back
  assign rot_word = ring.rot_en ? {prev_word[23:0], prev_word[31:24]} : prev_word;
  assign subbed   = sub_word(rot_word);
  assign temp     = (ring.rot_en || ring.sub_en) ? subbed : prev_word;
  assign new_word = temp ^ {(ring.rot_en ? rcon : 8'h00), 24'h000000} ^ cell_word[0];

  // Output data register
  assign sched_d = ring.echo ? key_word_i : new_word;

  always_ff @(posedge clk_i) begin
    if (ring.out_load) begin
      sched_q <= sched_d;
    end
  end

  assign schedule_word_o = sched_q;

endmodule

// ----- hw/rtl/aesk_chk.sv -----
// ----------------------------------------------------------------------------
// AES key expansion port checker
// Port-level checks on the key expansion block, bound to the top level.
// ----------------------------------------------------------------------------
`include "aes_key_expansion_assert.svh"

module aesk_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [aesk_pkg::WORD_W-1:0]  key_word_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [aesk_pkg::WORD_W-1:0]  schedule_word_o,
  input logic [aesk_pkg::IDX_W-1:0]   word_number_o,
  input logic                         final_word_o
);
  import aesk_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // A stalled output item holds
  `AESK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
    out_valid_o && $stable(schedule_word_o) && $stable(word_number_o))

  // A key word is echoed in the next cycle
  `AESK_ASSERT_NEXT(a_key_echo, clk_i, rst_ni, in_acc,
    out_valid_o && (schedule_word_o == $past(key_word_i)))

  // A key word is only taken when the output register can free up
  `AESK_ASSERT_IMPL(a_in_room, clk_i, rst_ni, in_acc, !out_stall)

  // The final word is the last word of one of the three schedules
  `AESK_ASSERT_IMPL(a_final_num, clk_i, rst_ni, out_valid_o && final_word_o,
    (word_number_o == LAST_WORD_128) || (word_number_o == LAST_WORD_192) ||
    (word_number_o == LAST_WORD_256))

endmodule

bind aes_key_expansion aesk_chk u_aesk_chk (.*);
